// ===== rtl/core/icef_pkg.sv =====
// shared types and constants of the interrupt controller with event fifo
// used by every module under rtl/core; depends on nothing
package icef_pkg;

	localparam int LINE_W     = 5;
	localparam int WORD_W     = 32;
	localparam int EVENT_ID_W = 8;
	localparam int OQ_DEPTH   = 3;
	localparam int OQ_CW      = 2;

	// request kinds carried on tuser
	localparam logic [2:0] REQ_READ  = 3'd0;
	localparam logic [2:0] REQ_WRITE = 3'd1;
	localparam logic [2:0] REQ_EVENT = 3'd2;
	localparam logic [2:0] REQ_ACK   = 3'd3;
	localparam logic [2:0] REQ_LINE  = 3'd4;

	// bus register map
	localparam logic [3:0] REG_MASK     = 4'd0;
	localparam logic [3:0] REG_MASK_SET = 4'd1;
	localparam logic [3:0] REG_MASK_CLR = 4'd2;
	localparam logic [3:0] REG_STAT     = 4'd3;
	localparam logic [3:0] REG_STAT_SET = 4'd4;
	localparam logic [3:0] REG_STAT_CLR = 4'd5;
	localparam logic [3:0] REG_ACK      = 4'd6;
	localparam logic [3:0] REG_ACK_SET  = 4'd7;
	localparam logic [3:0] REG_ACK_CLR  = 4'd8;
	localparam logic [3:0] REG_FIFO     = 4'd9;

	// configuration register indexes
	localparam logic CFG_FIFO_IRQ_EN   = 1'b0;
	localparam logic CFG_FIFO_IRQ_LINE = 1'b1;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_op_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic multi;
	} fifo_stat_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              access_error;
		logic              irq_update;
		logic              irq_active;
		logic [LINE_W-1:0] irq_number;
		logic              event_dropped;
	} irq_res_t;

	// highest set bit by halving the window, five levels
	function automatic logic [LINE_W-1:0] top_line(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] w;
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo_mask;
		logic [LINE_W-1:0] n;
		w = v;
		n = '0;
		for (int l = LINE_W - 1; l >= 0; l--) begin
			lo_mask = (WORD_W'(1) << (1 << l)) - WORD_W'(1);
			hi = (w >> (1 << l)) & lo_mask;
			if (hi != '0) begin
				n[l] = 1'b1;
				w = hi;
			end else begin
				w = w & lo_mask;
			end
		end
		return n;
	endfunction

endpackage

// ===== rtl/core/interrupt_controller_event_fifo.sv =====
// 32-line interrupt controller with mask/status/ack words and an event fifo
// top level; depends on icef_pkg, icef_irq_regs, icef_event_fifo, icef_out_queue
//
// Usage: each transaction on the s_axis channel is one request, its kind on
// s_axis_tuser (bus read, bus write, fifo event, acknowledge, line event).
// Every request gives exactly one result transaction on m_axis, in order.
// Two configuration registers (fifo irq enable at 0x0, fifo irq line at 0x4)
// sit on the APB port; write them only while no request is in flight.
// A result passes the res_s1 stage register and then the output queue before it is offered.
// Throughput: one request per cycle while s_axis_tready is high; mask, status and
// ack update and the 32-bit priority encode happen in the accept cycle, and a fifo
// pop reads the event memory at the accepting edge, its registered data joining the
// result in the next cycle.
// Results go through a three-entry queue, so s_axis_tready stays high while
// up to two results wait; when the receiver stalls longer, s_axis_tready
// drops until the queue drains.
// Reset clears mask, status, ack, send tracking, the fifo and result queue pointers,
// the stage valid and the configuration; the event memory itself is not cleared.
module interrupt_controller_event_fifo #(
	parameter int FIFO_DEPTH = 8,
	parameter int EVENT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// reg_index[3:0], word_access[4], write_data[36:5], event_id[44:37],
	// line_id[49:45], zero fill [55:50]
	input  logic [55:0] s_axis_tdata,
	// req_type[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_data[31:0], access_error[32], irq_update[33], irq_active[34],
	// irq_number[39:35], event_dropped[40], zero fill [47:41]
	output logic [47:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import icef_pkg::*;

	localparam int EV_W = (EVENT_BITS < EVENT_ID_W) ? EVENT_BITS : EVENT_ID_W;

	logic              cfg_en_q;
	logic [LINE_W-1:0] cfg_line_q;
	logic              cfg_wr;

	logic              accept;
	fifo_op_t          fop;
	fifo_stat_t        fstat;
	logic [EV_W-1:0]   fifo_rd;
	irq_res_t          res;

	logic              valid_s1;
	logic              pop_s1;
	irq_res_t          res_s1;
	irq_res_t          q_din;
	irq_res_t          q_dout;
	logic [OQ_CW-1:0]  q_count;
	logic [OQ_CW:0]    q_used;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_en_q   <= 1'b0;
			cfg_line_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				CFG_FIFO_IRQ_EN:   cfg_en_q   <= pwdata[0];
				CFG_FIFO_IRQ_LINE: cfg_line_q <= pwdata[LINE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			CFG_FIFO_IRQ_EN:   prdata = {31'd0, cfg_en_q};
			CFG_FIFO_IRQ_LINE: prdata = {{(32 - LINE_W){1'b0}}, cfg_line_q};
			default:           prdata = '0;
		endcase
	end

	// accept only while the queue can still take everything in flight
	assign q_used        = {1'b0, q_count} + {{OQ_CW{1'b0}}, valid_s1};
	assign s_axis_tready = (q_used < (OQ_CW + 1)'(OQ_DEPTH));
	assign accept        = s_axis_tvalid && s_axis_tready;

	icef_irq_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.req_type    (s_axis_tuser),
		.reg_index   (s_axis_tdata[3:0]),
		.word_access (s_axis_tdata[4]),
		.write_data  (s_axis_tdata[36:5]),
		.line_id     (s_axis_tdata[49:45]),
		.cfg_en      (cfg_en_q),
		.cfg_line    (cfg_line_q),
		.fstat       (fstat),
		.fop         (fop),
		.res         (res)
	);

	icef_event_fifo #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.EV_W       (EV_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (fop),
		.push_data (s_axis_tdata[37 + EV_W - 1:37]),
		.stat      (fstat),
		.rd_data   (fifo_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pop_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			pop_s1   <= fop.pop;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// popped event arrives from the memory in this stage
	always_comb begin
		q_din = res_s1;
		if (pop_s1) begin
			q_din.read_data = WORD_W'(fifo_rd);
		end
	end

	icef_out_queue u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.din       (q_din),
		.pop       (m_axis_tvalid && m_axis_tready),
		.dout      (q_dout),
		.not_empty (m_axis_tvalid),
		.count     (q_count)
	);

	// first field in the lowest bits
	assign m_axis_tdata = {7'd0, q_dout.event_dropped, q_dout.irq_number, q_dout.irq_active,
		q_dout.irq_update, q_dout.access_error, q_dout.read_data};

endmodule

// ===== rtl/core/icef_event_fifo.sv =====
// ring fifo of event ids held in a synchronous memory with registered read
// depends on icef_pkg
module icef_event_fifo #(
	parameter int FIFO_DEPTH = 8,
	parameter int EV_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  icef_pkg::fifo_op_t   op,
	input  logic [EV_W-1:0]      push_data,
	output icef_pkg::fifo_stat_t stat,
	output logic [EV_W-1:0]      rd_data
);
	import icef_pkg::*;

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [EV_W-1:0] mem [FIFO_DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   count_q;
	logic [EV_W-1:0] rd_q;

	always_comb begin
		stat.empty = (count_q == '0);
		stat.full  = (count_q == CW'(FIFO_DEPTH));
		stat.multi = (count_q > CW'(1));
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[wp_q] <= push_data;
		end
		if (op.pop) begin
			rd_q <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (op.push) begin
				wp_q    <= (wp_q == PW'(FIFO_DEPTH - 1)) ? '0 : wp_q + PW'(1);
				count_q <= count_q + CW'(1);
			end else if (op.pop) begin
				rp_q    <= (rp_q == PW'(FIFO_DEPTH - 1)) ? '0 : rp_q + PW'(1);
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/core/icef_irq_regs.sv =====
// mask, status and ack words, request decode and interrupt send tracking
// depends on icef_pkg; drives the event fifo operations
module icef_irq_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [2:0]                      req_type,
	input  logic [3:0]                      reg_index,
	input  logic                            word_access,
	input  logic [icef_pkg::WORD_W-1:0]     write_data,
	input  logic [icef_pkg::LINE_W-1:0]     line_id,
	input  logic                            cfg_en,
	input  logic [icef_pkg::LINE_W-1:0]     cfg_line,
	input  icef_pkg::fifo_stat_t            fstat,
	output icef_pkg::fifo_op_t              fop,
	output icef_pkg::irq_res_t              res
);
	import icef_pkg::*;

	logic [WORD_W-1:0] mask_q, stat_q, ack_q;
	logic [WORD_W-1:0] mask_n, stat_n, ack_n;
	logic              sent_valid_q;
	logic [LINE_W-1:0] sent_line_q;
	logic [WORD_W-1:0] fifo_bit, line_bit, masked;
	logic              wr, chk, ack_op, now_valid, upd;
	logic [LINE_W-1:0] now_line;
	fifo_op_t          op;

	assign fifo_bit = WORD_W'(1) << cfg_line;
	assign line_bit = WORD_W'(1) << line_id;
	assign wr       = (req_type == REQ_WRITE);

	always_comb begin
		mask_n = mask_q;
		stat_n = stat_q;
		ack_n  = ack_q;
		chk    = 1'b0;
		ack_op = 1'b0;
		op     = '0;
		res    = '0;
		unique case (req_type)
			REQ_READ, REQ_WRITE: begin
				if (!word_access) begin
					res.access_error = 1'b1;
				end else if (!wr && (reg_index inside {REG_MASK_SET, REG_MASK_CLR,
						REG_STAT_SET, REG_STAT_CLR, REG_ACK_SET, REG_ACK_CLR})) begin
					res.access_error = 1'b1;
				end else if (wr && reg_index == REG_FIFO) begin
					res.access_error = 1'b1;
				end else begin
					unique case (reg_index)
						REG_MASK: begin
							if (wr) begin
								mask_n = write_data;
								chk    = 1'b1;
							end else begin
								res.read_data = mask_q;
							end
						end
						REG_MASK_SET: begin
							mask_n = mask_q | write_data;
							chk    = 1'b1;
						end
						REG_MASK_CLR: begin
							mask_n = mask_q & ~write_data;
							chk    = 1'b1;
						end
						REG_STAT: begin
							if (wr) begin
								stat_n = write_data;
								chk    = 1'b1;
							end else begin
								res.read_data = stat_q;
							end
						end
						REG_STAT_SET: begin
							stat_n = stat_q | write_data;
							chk    = 1'b1;
						end
						REG_STAT_CLR: begin
							stat_n = stat_q & ~write_data;
							chk    = 1'b1;
						end
						REG_ACK: begin
							if (wr) begin
								ack_n = write_data;
							end else begin
								res.read_data = ack_q;
							end
						end
						REG_ACK_SET: ack_n = ack_q | write_data;
						REG_ACK_CLR: ack_n = ack_q & ~write_data;
						REG_FIFO: begin
							// read data comes from the fifo memory in the next cycle
							if (!fstat.empty) begin
								op.pop = 1'b1;
								if (fstat.multi && cfg_en) begin
									stat_n = stat_q | fifo_bit;
									chk    = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
			end
			REQ_EVENT: begin
				if (fstat.full) begin
					res.event_dropped = 1'b1;
				end else begin
					op.push = 1'b1;
					if (fstat.empty && cfg_en) begin
						stat_n = stat_q | fifo_bit;
						chk    = 1'b1;
					end
				end
			end
			REQ_ACK: begin
				stat_n = stat_q & ~line_bit;
				ack_n  = ack_q | line_bit;
				chk    = 1'b1;
				ack_op = 1'b1;
			end
			REQ_LINE: begin
				stat_n = stat_q | line_bit;
				chk    = 1'b1;
			end
			default: ;
		endcase

		masked    = stat_n & mask_n;
		now_valid = (masked != '0);
		now_line  = top_line(masked);
		upd       = chk && ((now_valid != sent_valid_q) ||
			(now_valid && now_line != sent_line_q));
		res.irq_update = upd;
		res.irq_active = now_valid;
		res.irq_number = now_line;
	end

	assign fop.push = accept && op.push;
	assign fop.pop  = accept && op.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q       <= '0;
			stat_q       <= '0;
			ack_q        <= '0;
			sent_valid_q <= 1'b0;
			sent_line_q  <= '0;
		end else if (accept) begin
			mask_q <= mask_n;
			stat_q <= stat_n;
			ack_q  <= ack_n;
			// an acknowledge forgets what was sent so the next check sends again
			if (ack_op) begin
				sent_valid_q <= 1'b0;
				sent_line_q  <= '0;
			end else if (upd) begin
				sent_valid_q <= now_valid;
				sent_line_q  <= now_line;
			end
		end
	end

endmodule

// ===== rtl/core/icef_out_queue.sv =====
// small result queue between the pipeline and the output stream
// depends on icef_pkg
module icef_out_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  icef_pkg::irq_res_t           din,
	input  logic                         pop,
	output icef_pkg::irq_res_t           dout,
	output logic                         not_empty,
	output logic [icef_pkg::OQ_CW-1:0]   count
);
	import icef_pkg::*;

	irq_res_t         entries [OQ_DEPTH];
	logic [OQ_CW-1:0] wp_q, rp_q, count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == OQ_CW'(OQ_DEPTH - 1)) ? '0 : wp_q + OQ_CW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == OQ_CW'(OQ_DEPTH - 1)) ? '0 : rp_q + OQ_CW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + OQ_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - OQ_CW'(1);
			end
		end
	end

	assign dout      = entries[rp_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench of interrupt_controller_event_fifo: requests in on s_axis,
// one result per request compared against a cycle-free prediction of the controller
// depends on icef_pkg and rtl/core/interrupt_controller_event_fifo.sv
module tb_top;
	import icef_pkg::*;

	localparam int EVENT_SLOTS = 8;
	localparam logic [3:0] REG_UNMAPPED_LO = 4'd10;
	localparam logic [3:0] REG_UNMAPPED_HI = 4'd15;
	localparam logic [2:0] REQ_UNUSED_LO   = 3'd5;
	localparam logic [2:0] REQ_UNUSED_HI   = 3'd7;
	localparam int RANDOM_PER_PHASE = 130;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predicted controller state
	logic [31:0] pend_word, mask_word, ack_word;
	logic        sent_valid, upd_flag;
	logic [4:0]  sent_num;
	logic [7:0]  event_mem [EVENT_SLOTS];
	logic [2:0]  push_ptr, pop_ptr;
	int unsigned event_count;
	logic        fifo_irq_en;
	logic [4:0]  fifo_irq_num;

	irq_res_t    irq_results_due [$];
	int unsigned mismatches = 0;
	bit          idle_on = 1'b1;
	int unsigned stall_left = 0;

	interrupt_controller_event_fifo #(
		.FIFO_DEPTH(EVENT_SLOTS),
		.EVENT_BITS(EVENT_ID_W)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("interrupt_controller_event_fifo verification failed");
		$finish;
	end

	function automatic int highest_line(logic [31:0] v);
		for (int i = 31; i >= 0; i--)
			if (v[i])
				return i;
		return -1;
	endfunction

	// resend the request whenever the top masked pending line changes
	function automatic void resend_check();
		int top;
		logic now_valid;
		logic [4:0] now_num;
		top = highest_line(pend_word & mask_word);
		now_valid = (top >= 0);
		now_num = now_valid ? 5'(top) : 5'd0;
		if (now_valid != sent_valid || (now_valid && now_num != sent_num)) begin
			sent_valid = now_valid;
			sent_num = now_num;
			upd_flag = 1'b1;
		end
	endfunction

	function automatic void set_pending(logic [31:0] v);
		pend_word = v;
		resend_check();
	endfunction

	function automatic irq_res_t predict_irq_result(logic [2:0] kind, logic [3:0] idx,
			logic word, logic [31:0] data, logic [7:0] ev, logic [4:0] line);
		irq_res_t r;
		logic wr;
		int top;
		r = '0;
		upd_flag = 1'b0;
		case (kind)
			REQ_READ, REQ_WRITE: begin
				wr = (kind == REQ_WRITE);
				if (!word) begin
					r.access_error = 1'b1;
				end else if (!wr && idx inside {REG_MASK_SET, REG_MASK_CLR, REG_STAT_SET,
						REG_STAT_CLR, REG_ACK_SET, REG_ACK_CLR}) begin
					r.access_error = 1'b1;
				end else if (wr && idx == REG_FIFO) begin
					r.access_error = 1'b1;
				end else begin
					case (idx)
						REG_MASK: begin
							if (wr) begin
								mask_word = data;
								resend_check();
							end else begin
								r.read_data = mask_word;
							end
						end
						REG_MASK_SET: begin
							mask_word |= data;
							resend_check();
						end
						REG_MASK_CLR: begin
							mask_word &= ~data;
							resend_check();
						end
						REG_STAT: begin
							if (wr)
								set_pending(data);
							else
								r.read_data = pend_word;
						end
						REG_STAT_SET: set_pending(pend_word | data);
						REG_STAT_CLR: set_pending(pend_word & ~data);
						REG_ACK: begin
							if (wr)
								ack_word = data;
							else
								r.read_data = ack_word;
						end
						REG_ACK_SET: ack_word |= data;
						REG_ACK_CLR: ack_word &= ~data;
						REG_FIFO: begin
							if (event_count != 0) begin
								r.read_data = {24'd0, event_mem[pop_ptr]};
								pop_ptr++;
								event_count--;
								if (event_count != 0 && fifo_irq_en)
									set_pending(pend_word | (32'd1 << fifo_irq_num));
							end
						end
						default: ;
					endcase
				end
			end
			REQ_EVENT: begin
				if (event_count >= EVENT_SLOTS) begin
					r.event_dropped = 1'b1;
				end else begin
					event_mem[push_ptr] = ev;
					push_ptr++;
					event_count++;
					if (fifo_irq_en && event_count == 1)
						set_pending(pend_word | (32'd1 << fifo_irq_num));
				end
			end
			REQ_ACK: begin
				set_pending(pend_word & ~(32'd1 << line));
				ack_word |= 32'd1 << line;
				sent_valid = 1'b0;
				sent_num = '0;
			end
			REQ_LINE: set_pending(pend_word | (32'd1 << line));
			default: ;
		endcase
		top = highest_line(pend_word & mask_word);
		r.irq_update = upd_flag;
		r.irq_active = (top >= 0);
		r.irq_number = (top >= 0) ? 5'(top) : 5'd0;
		return r;
	endfunction

	task automatic send_req(logic [2:0] kind, logic [3:0] idx, logic word, logic [31:0] data,
			logic [7:0] ev, logic [4:0] line);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {6'd0, line, ev, data, word, idx};
		do @(posedge clk); while (!s_axis_tready);
		irq_results_due.push_back(predict_irq_result(kind, idx, word, data, ev, line));
	endtask

	// drop the request stream and let every result come back
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (irq_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == CFG_FIFO_IRQ_EN)
			fifo_irq_en = value[0];
		else
			fifo_irq_num = value[4:0];
		@(posedge clk);
	endtask

	// upper bits carry noise, only the low bits of each register count
	task automatic set_config(logic en, logic [4:0] line);
		wait_idle();
		apb_write(CFG_FIFO_IRQ_EN, {31'($urandom), en});
		apb_write(CFG_FIFO_IRQ_LINE, {27'($urandom), line});
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// result side: random stall bursts and in-order comparison
	always @(posedge clk) begin
		irq_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (irq_results_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result transaction, expected none, actual %h",
					$time, m_axis_tdata);
			end else begin
				want = irq_results_due.pop_front();
				check_field("read_data", want.read_data, m_axis_tdata[31:0]);
				check_field("access_error", 32'(want.access_error), 32'(m_axis_tdata[32]));
				check_field("irq_update", 32'(want.irq_update), 32'(m_axis_tdata[33]));
				check_field("irq_active", 32'(want.irq_active), 32'(m_axis_tdata[34]));
				check_field("irq_number", 32'(want.irq_number), 32'(m_axis_tdata[39:35]));
				check_field("event_dropped", 32'(want.event_dropped), 32'(m_axis_tdata[40]));
			end
		end
		if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 12);
		if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic test_register_access();
		send_req(REQ_READ, REG_MASK, 1'b1, $urandom, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_MASK, 1'b1, 32'hFFFF_FFFF, 8'($urandom), 5'($urandom));
		send_req(REQ_LINE, 4'($urandom), 1'b0, $urandom, 8'($urandom), 5'd31);
		send_req(REQ_LINE, 4'($urandom), 1'b1, $urandom, 8'($urandom), 5'd0);
		send_req(REQ_READ, REG_STAT, 1'b1, $urandom, 8'($urandom), 5'($urandom));
		// acknowledge of the top line drops the request to the next one
		send_req(REQ_ACK, 4'($urandom), 1'b0, $urandom, 8'($urandom), 5'd31);
		send_req(REQ_READ, REG_ACK, 1'b1, $urandom, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_ACK_SET, 1'b1, 32'h0000_00F0, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_ACK_CLR, 1'b1, 32'h8000_0000, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_MASK_CLR, 1'b1, 32'h0000_0001, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_MASK_SET, 1'b1, 32'h0000_0001, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_STAT_SET, 1'b1, 32'hAAAA_5555, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_STAT_CLR, 1'b1, 32'hFFFF_FFFF, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_STAT, 1'b1, 32'h0001_0000, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_ACK, 1'b1, 32'h0000_0000, 8'($urandom), 5'($urandom));
	endtask

	task automatic test_access_errors();
		logic [3:0] alias_regs [3];
		alias_regs = '{REG_MASK_SET, REG_STAT_CLR, REG_ACK_SET};
		send_req(REQ_READ, REG_MASK, 1'b0, $urandom, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_STAT, 1'b0, 32'hFFFF_FFFF, 8'($urandom), 5'($urandom));
		foreach (alias_regs[i])
			send_req(REQ_READ, alias_regs[i], 1'b1, $urandom, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_FIFO, 1'b1, $urandom, 8'($urandom), 5'($urandom));
		send_req(REQ_READ, REG_UNMAPPED_HI, 1'b1, $urandom, 8'($urandom), 5'($urandom));
		send_req(REQ_WRITE, REG_UNMAPPED_LO, 1'b1, $urandom, 8'($urandom), 5'($urandom));
		send_req(REQ_READ, REG_FIFO, 1'b1, $urandom, 8'($urandom), 5'($urandom));
		for (int k = REQ_UNUSED_LO; k <= REQ_UNUSED_HI; k++)
			send_req(3'(k), 4'($urandom), 1'b1, $urandom, 8'($urandom), 5'($urandom));
	endtask

	task automatic test_event_fifo();
		set_config(1'b1, 5'd31);
		send_req(REQ_WRITE, REG_MASK, 1'b1, 32'h8000_0101, 8'($urandom), 5'($urandom));
		send_req(REQ_EVENT, 4'($urandom), 1'b1, $urandom, 8'h00, 5'($urandom));
		send_req(REQ_EVENT, 4'($urandom), 1'b0, $urandom, 8'hFF, 5'($urandom));
		// one more than the fifo holds, the last one is dropped
		repeat (EVENT_SLOTS - 1)
			send_req(REQ_EVENT, 4'($urandom), 1'b1, $urandom, 8'($urandom), 5'($urandom));
		send_req(REQ_ACK, 4'($urandom), 1'b1, $urandom, 8'($urandom), 5'd31);
		repeat (EVENT_SLOTS / 2)
			send_req(REQ_READ, REG_FIFO, 1'b1, $urandom, 8'($urandom), 5'($urandom));
		send_req(REQ_ACK, 4'($urandom), 1'b1, $urandom, 8'($urandom), 5'd31);
		repeat (EVENT_SLOTS / 2 + 1)
			send_req(REQ_READ, REG_FIFO, 1'b1, $urandom, 8'($urandom), 5'($urandom));
	endtask

	task automatic random_item();
		logic [2:0] kind;
		logic [3:0] idx;
		logic word;
		logic [31:0] data;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		idx = 4'($urandom_range(REG_MASK, REG_FIFO));
		if ($urandom_range(0, 15) == 0)
			idx = 4'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI));
		word = ($urandom_range(0, 15) != 0);
		case ($urandom_range(0, 3))
			0: data = 32'd1 << $urandom_range(0, 31);
			1: data = $urandom_range(0, 1) ? '1 : '0;
			default: data = $urandom;
		endcase
		if (pick < 28) begin
			kind = REQ_WRITE;
		end else if (pick < 48) begin
			kind = REQ_READ;
			if ($urandom_range(0, 1))
				idx = REG_FIFO;
		end else if (pick < 64) begin
			kind = REQ_EVENT;
		end else if (pick < 76) begin
			kind = REQ_ACK;
		end else if (pick < 96) begin
			kind = REQ_LINE;
		end else begin
			kind = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
		end
		send_req(kind, idx, word, data, 8'($urandom), 5'($urandom));
	endtask

	task automatic test_random_traffic();
		logic [4:0] lines [6];
		logic       ens [6];
		lines = '{5'd0, 5'd0, 5'd31, 5'($urandom), 5'($urandom), 5'($urandom)};
		ens = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
		for (int p = 0; p < 6; p++) begin
			set_config(ens[p], lines[p]);
			repeat (RANDOM_PER_PHASE) random_item();
		end
	endtask

	task automatic test_full_rate();
		set_config(1'b1, 5'($urandom));
		idle_on = 1'b0;
		repeat (80) random_item();
	endtask

	initial begin
		pend_word = '0;
		mask_word = '0;
		ack_word = '0;
		sent_valid = 1'b0;
		sent_num = '0;
		upd_flag = 1'b0;
		push_ptr = '0;
		pop_ptr = '0;
		event_count = 0;
		fifo_irq_en = 1'b0;
		fifo_irq_num = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_access_errors();
		test_event_fifo();
		test_random_traffic();
		test_full_rate();
		wait_idle();
		if (mismatches == 0)
			$display("interrupt_controller_event_fifo verification clean");
		else
			$display("interrupt_controller_event_fifo verification failed");
		$finish;
	end

endmodule
